/* sv/flptw_pkg.sv */
// ----------------------------------------------------------------------------
// flptw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package flptw_pkg;

  localparam int unsigned AddrW  = 52;
  localparam int unsigned VaW    = 48;
  localparam int unsigned EntryW = 64;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned OffW   = 30;
  localparam int unsigned LvlW   = 3;

  localparam int unsigned EntryPresentBit = 0;
  localparam int unsigned EntryLargeBit   = 7;

  localparam logic [LvlW-1:0] LVL_IDLE = 3'd0;
  localparam logic [LvlW-1:0] LVL_1    = 3'd1;
  localparam logic [LvlW-1:0] LVL_2    = 3'd2;
  localparam logic [LvlW-1:0] LVL_3    = 3'd3;
  localparam logic [LvlW-1:0] LVL_4    = 3'd4;

  typedef enum logic [1:0] {
    OP_READ,
    OP_FAULT,
    OP_MAP
  } op_e;

  typedef enum logic [1:0] {
    SIZE_4K = 2'd0,
    SIZE_2M = 2'd1,
    SIZE_1G = 2'd2
  } map_size_e;

  typedef struct packed {
    op_e              op;
    map_size_e        size;
    logic [AddrW-1:0] base;
    logic [IdxW-1:0]  index;
    logic [OffW-1:0]  offset;
  } cmd_t;

endpackage

/* sv/flptw_front.sv */
// ----------------------------------------------------------------------------
// flptw_front
// Accepts beats, tracks the walk level and held address, and turns each
// beat into a command for the back end, except an entry beat with no walk.
// ----------------------------------------------------------------------------
module flptw_front #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [flptw_pkg::AddrW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         func_i,
  input  logic [flptw_pkg::VaW-1:0]    virtual_address_i,
  input  logic [flptw_pkg::EntryW-1:0] entry_data_i,
  output logic                         push_o,
  output flptw_pkg::cmd_t              cmd_o
);
  import flptw_pkg::*;

  localparam logic [EntryW-1:0] PhysMaskFull =
    ((EntryW'(1) << PHYS_ADDR_BITS) - EntryW'(1)) & ~EntryW'(12'hFFF);
  localparam logic [AddrW-1:0] PhysMask = PhysMaskFull[AddrW-1:0];

  logic [AddrW-1:0] root_q;
  logic [LvlW-1:0]  level_q, level_d;
  logic [VaW-1:0]   held_va_q, held_va_d;
  logic             accept;
  logic [AddrW-1:0] entry_base;
  logic             present, large_page;

  function automatic logic [IdxW-1:0] level_index(input logic [VaW-1:0] va,
                                                  input logic [LvlW-1:0] lvl);
    logic [IdxW-1:0] idx;
    unique case (lvl)
      LVL_4:   idx = va[47:39];
      LVL_3:   idx = va[38:30];
      LVL_2:   idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  assign accept     = in_valid_i && in_ready_i;
  assign entry_base = entry_data_i[AddrW-1:0] & PhysMask;
  assign present    = entry_data_i[EntryPresentBit];
  assign large_page = entry_data_i[EntryLargeBit];

  always_comb begin
    level_d        = level_q;
    held_va_d      = held_va_q;
    push_o         = 1'b0;
    cmd_o.op       = OP_FAULT;
    cmd_o.size     = SIZE_4K;
    cmd_o.base     = entry_base;
    cmd_o.index    = level_index(held_va_q, level_q - LvlW'(1));
    cmd_o.offset   = held_va_q[OffW-1:0];
    if (accept) begin
      if (!func_i) begin
        held_va_d    = virtual_address_i;
        push_o       = 1'b1;
        cmd_o.base   = root_q & PhysMask;
        cmd_o.index  = level_index(virtual_address_i, LVL_4);
        if (virtual_address_i == '0) begin
          level_d  = LVL_IDLE;
          cmd_o.op = OP_FAULT;
        end else begin
          level_d  = LVL_4;
          cmd_o.op = OP_READ;
        end
      end else if (level_q < LVL_1 || level_q > LVL_4) begin
        level_d = LVL_IDLE;
      end else begin
        push_o  = 1'b1;
        level_d = LVL_IDLE;
        if (!present || (level_q == LVL_4 && large_page)) begin
          cmd_o.op = OP_FAULT;
        end else if (level_q == LVL_3 && large_page) begin
          cmd_o.op   = OP_MAP;
          cmd_o.size = SIZE_1G;
        end else if (level_q == LVL_2 && large_page) begin
          cmd_o.op   = OP_MAP;
          cmd_o.size = SIZE_2M;
        end else if (level_q == LVL_1) begin
          cmd_o.op   = OP_MAP;
          cmd_o.size = SIZE_4K;
        end else begin
          cmd_o.op = OP_READ;
          level_d  = level_q - LvlW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q    <= '0;
      level_q   <= LVL_IDLE;
      held_va_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        root_q <= cfg_data_i;
      end
      level_q   <= level_d;
      held_va_q <= held_va_d;
    end
  end

endmodule

/* sv/flptw_queue.sv */
// ----------------------------------------------------------------------------
// flptw_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module flptw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  flptw_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output flptw_pkg::cmd_t cmd_o
);
  import flptw_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

/* sv/flptw_back.sv */
// ----------------------------------------------------------------------------
// flptw_back
// Builds read requests and translation results from queued commands and
// holds them in the output register.
// ----------------------------------------------------------------------------
module flptw_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  flptw_pkg::cmd_t             cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [flptw_pkg::AddrW-1:0] read_address_o,
  output logic [flptw_pkg::AddrW-1:0] physical_address_o,
  output logic                        translated_o,
  output logic [1:0]                  mapping_size_o
);
  import flptw_pkg::*;

  logic             valid_q;
  logic             kind_q, kind_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic [AddrW-1:0] pa_q, pa_d;
  logic             ok_q, ok_d;
  logic [1:0]       size_q, size_d;
  logic [AddrW-1:0] page_addr;

  assign pop_o = q_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    case (cmd_i.size)
      SIZE_1G: page_addr = {cmd_i.base[AddrW-1:30], cmd_i.offset[29:0]};
      SIZE_2M: page_addr = {cmd_i.base[AddrW-1:21], cmd_i.offset[20:0]};
      default: page_addr = {cmd_i.base[AddrW-1:12], cmd_i.offset[11:0]};
    endcase
  end

  always_comb begin
    kind_d    = 1'b1;
    rd_addr_d = '0;
    pa_d      = '0;
    ok_d      = 1'b0;
    size_d    = 2'd0;
    unique case (cmd_i.op)
      OP_READ: begin
        kind_d    = 1'b0;
        rd_addr_d = cmd_i.base + AddrW'({cmd_i.index, 3'b000});
      end
      OP_MAP: begin
        pa_d   = page_addr;
        ok_d   = 1'b1;
        size_d = 2'(cmd_i.size);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q    <= kind_d;
      rd_addr_q <= rd_addr_d;
      pa_q      <= pa_d;
      ok_q      <= ok_d;
      size_q    <= size_d;
    end
  end

  assign out_valid_o        = valid_q;
  assign kind_o             = kind_q;
  assign read_address_o     = rd_addr_q;
  assign physical_address_o = pa_q;
  assign translated_o       = ok_q;
  assign mapping_size_o     = size_q;

endmodule

/* sv/four_level_page_table_walker.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Walks four-level x86-64 page tables one beat at a time.
// ----------------------------------------------------------------------------
// Takes one beat per cycle. A translate beat (func 0) yields a read request
// for the top-level entry, or a failed result for address zero; each entry
// beat (func 1) yields the next read request or the final result, and an
// entry beat with no walk in progress yields nothing. The front end
// classifies a beat and writes a command into the queue when it is taken;
// the back end moves the queue head into its output register when that
// register is empty or the output is not stalled. A two-entry queue
// separates the two, so input stalls only when the output side has been
// stalled long enough to fill it. The root table base is written through
// the config channel, which is always ready.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [flptw_pkg::AddrW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [flptw_pkg::VaW-1:0]    virtual_address_i,
  input  logic [flptw_pkg::EntryW-1:0] entry_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [flptw_pkg::AddrW-1:0]  read_address_o,
  output logic [flptw_pkg::AddrW-1:0]  physical_address_o,
  output logic                         translated_o,
  output logic [1:0]                   mapping_size_o
);
  import flptw_pkg::*;

  logic push, full, pop, q_valid;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  flptw_front #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (!full),
    .func_i            (func_i),
    .virtual_address_i (virtual_address_i),
    .entry_data_i      (entry_data_i),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  flptw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  flptw_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .cmd_i              (head_cmd),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .read_address_o     (read_address_o),
    .physical_address_o (physical_address_o),
    .translated_o       (translated_o),
    .mapping_size_o     (mapping_size_o)
  );

endmodule

/* sim/four_level_page_table_walker_checker.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker_checker
// Watches the config, request and result channels of the page table walker,
// keeps its own copy of the walk state and compares every result beat
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
package flptw_tb_pkg;

  typedef enum logic {
    FUNC_TRANSLATE = 1'b0,
    FUNC_ENTRY     = 1'b1
  } func_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

endpackage

module four_level_page_table_walker_checker
  import flptw_pkg::*;
  import flptw_tb_pkg::*;
#(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [AddrW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              func_i,
  input  logic [VaW-1:0]    virtual_address_i,
  input  logic [EntryW-1:0] entry_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              kind_i,
  input  logic [AddrW-1:0]  read_address_i,
  input  logic [AddrW-1:0]  physical_address_i,
  input  logic              translated_i,
  input  logic [1:0]        mapping_size_i,
  output int                fail_count_o,
  output int                outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [AddrW-1:0] FrameMask =
    AddrW'(((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'hFFF);

  typedef struct {
    kind_e            kind;
    logic [AddrW-1:0] read_addr;
    logic [AddrW-1:0] phys_addr;
    logic             hit;
    logic [1:0]       size;
  } walk_result_t;

  walk_result_t     walk_result_q[$];
  logic [AddrW-1:0] root_base = '0;
  logic [LvlW-1:0]  walk_lvl  = LVL_IDLE;
  logic [VaW-1:0]   held_va   = '0;
  int               fail_count = 0;
  int               pending    = 0;

  assign fail_count_o  = fail_count;
  assign outstanding_o = pending;

  // entry address inside a table: 9 index bits of the va per level
  function automatic logic [AddrW-1:0] slot_addr(input logic [AddrW-1:0] table_base,
                                                 input logic [VaW-1:0]   va,
                                                 input logic [LvlW-1:0]  lvl);
    logic [VaW-1:0] shifted;
    shifted = va >> (12 + IdxW * (lvl - 1));
    return {table_base[AddrW-1:12], shifted[IdxW-1:0], 3'b000};
  endfunction

  function automatic bit step_walk(input logic             fn,
                                   input logic [VaW-1:0]    va,
                                   input logic [EntryW-1:0] entry,
                                   output walk_result_t     res);
    logic [LvlW-1:0]  lvl;
    logic [AddrW-1:0] frame;
    res = '{kind: KIND_READ, read_addr: '0, phys_addr: '0, hit: 1'b0, size: SIZE_4K};
    if (fn == FUNC_TRANSLATE) begin
      held_va = va;
      if (va == '0) begin
        walk_lvl = LVL_IDLE;
        res.kind = KIND_DONE;
        return 1'b1;
      end
      walk_lvl = LVL_4;
      res.read_addr = slot_addr(root_base & FrameMask, va, LVL_4);
      return 1'b1;
    end
    if (walk_lvl == LVL_IDLE) return 1'b0;
    lvl      = walk_lvl;
    walk_lvl = LVL_IDLE;
    frame    = entry[AddrW-1:0] & FrameMask;
    res.kind = KIND_DONE;
    // not present, or large bit reserved at the top level
    if (!entry[EntryPresentBit] || (lvl == LVL_4 && entry[EntryLargeBit])) return 1'b1;
    if (lvl == LVL_3 && entry[EntryLargeBit]) begin
      res.phys_addr = {frame[AddrW-1:30], held_va[29:0]};
      res.hit       = 1'b1;
      res.size      = SIZE_1G;
    end else if (lvl == LVL_2 && entry[EntryLargeBit]) begin
      res.phys_addr = {frame[AddrW-1:21], held_va[20:0]};
      res.hit       = 1'b1;
      res.size      = SIZE_2M;
    end else if (lvl == LVL_1) begin
      res.phys_addr = {frame[AddrW-1:12], held_va[11:0]};
      res.hit       = 1'b1;
      res.size      = SIZE_4K;
    end else begin
      walk_lvl      = lvl - 1'b1;
      res.kind      = KIND_READ;
      res.read_addr = slot_addr(frame, held_va, walk_lvl);
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [AddrW-1:0] want,
                             input logic [AddrW-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    walk_result_t res;
    walk_result_t want;
    if (!rst_ni) begin
      root_base = '0;
      walk_lvl  = LVL_IDLE;
      held_va   = '0;
      walk_result_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) root_base = cfg_data_i;
      // result side first, so a beat can never match its own prediction early
      if (out_valid_i && !out_stall_i) begin
        if (walk_result_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat expected none, got kind %0h read %0h phys %0h",
                   $time, kind_i, read_address_i, physical_address_i);
        end else begin
          want = walk_result_q.pop_front();
          check_field("kind", AddrW'(want.kind), AddrW'(kind_i));
          check_field("read_address", want.read_addr, read_address_i);
          check_field("physical_address", want.phys_addr, physical_address_i);
          check_field("translated", AddrW'(want.hit), AddrW'(translated_i));
          check_field("mapping_size", AddrW'(want.size), AddrW'(mapping_size_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (step_walk(func_i, virtual_address_i, entry_data_i, res))
          walk_result_q.push_back(res);
      end
    end
    pending = walk_result_q.size();
  end

endmodule

/* sim/four_level_page_table_walker_test.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker_test
// Drives translate and entry beats into the page table walker: a directed
// set of corner walks, then random walks ending at every level, with
// aborted walks and stray entries, under several root bases and idle mixes.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_test;
  import flptw_pkg::*;
  import flptw_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 100000;
  localparam int SettleCycles = 4;
  localparam int PhaseItems   = 150;
  localparam int HoldCycles   = 300;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              cfg_valid_i       = 1'b0;
  logic              cfg_ready_o;
  logic [AddrW-1:0]  cfg_data_i        = '0;
  logic              in_valid_i        = 1'b0;
  logic              in_stall_o;
  logic              func_i            = 1'b0;
  logic [VaW-1:0]    virtual_address_i = '0;
  logic [EntryW-1:0] entry_data_i      = '0;
  logic              out_valid_o;
  logic              out_stall_i       = 1'b0;
  logic              kind_o;
  logic [AddrW-1:0]  read_address_o;
  logic [AddrW-1:0]  physical_address_o;
  logic              translated_o;
  logic [1:0]        mapping_size_o;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int item_count  = 0;
  bit hold_req    = 1'b0;

  four_level_page_table_walker i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .virtual_address_i, .entry_data_i,
    .out_valid_o, .out_stall_i, .kind_o, .read_address_o, .physical_address_o,
    .translated_o, .mapping_size_o
  );

  four_level_page_table_walker_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .virtual_address_i, .entry_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o),
    .read_address_i(read_address_o), .physical_address_i(physical_address_o),
    .translated_i(translated_o), .mapping_size_i(mapping_size_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off on request
  always @(negedge clk_i) begin : result_stall
    int hold_left;
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // returns just after the rising edge that took the beat
  task automatic push_beat(input func_e fn, input logic [VaW-1:0] va,
                           input logic [EntryW-1:0] entry);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    func_i            <= fn;
    virtual_address_i <= va;
    entry_data_i      <= entry;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (fn == FUNC_TRANSLATE || entry != '0 || va != '0) item_count++;
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_root(input logic [AddrW-1:0] base);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_walk();
    logic [VaW-1:0]    va;
    logic [EntryW-1:0] entry;
    logic [LvlW-1:0]   lvl;
    logic [LvlW-1:0]   cut;
    bit                present;
    bit                large_page;
    cut = ($urandom_range(99) < 8) ? LvlW'($urandom_range(LVL_4, LVL_1)) : LVL_IDLE;
    va  = ($urandom_range(99) < 2) ? '0 : VaW'(rand64());
    push_beat(FUNC_TRANSLATE, va, rand64());
    lvl = (va == '0) ? LVL_IDLE : LVL_4;
    while (lvl != LVL_IDLE) begin
      // abandoned walk: the next translate restarts
      if (lvl == cut) return;
      present = $urandom_range(99) < 92;
      case (lvl)
        LVL_4:        large_page = $urandom_range(99) < 4;
        LVL_3, LVL_2: large_page = $urandom_range(99) < 30;
        default:      large_page = $urandom_range(99) < 50;
      endcase
      entry                  = rand64();
      entry[EntryPresentBit] = present;
      entry[EntryLargeBit]   = large_page;
      push_beat(FUNC_ENTRY, VaW'(rand64()), entry);
      lvl = (!present || large_page || lvl == LVL_1) ? LVL_IDLE : lvl - 1'b1;
    end
    if ($urandom_range(99) < 6) begin
      push_beat(FUNC_ENTRY, VaW'(rand64()), rand64());
      item_count--;
    end
  endtask

  task automatic directed_walks();
    logic [EntryW-1:0] tbl;
    logic [EntryW-1:0] absent;
    tbl                    = '1;
    tbl[EntryLargeBit]     = 1'b0;
    absent                 = '1;
    absent[EntryPresentBit] = 1'b0;
    // entry with no walk running
    push_beat(FUNC_ENTRY, '0, '1);
    // zero address
    push_beat(FUNC_TRANSLATE, '0, '0);
    // all-ones va down to a 4 KiB page, PAT bit set at the last level
    push_beat(FUNC_TRANSLATE, '1, '0);
    push_beat(FUNC_ENTRY, '0, tbl);
    push_beat(FUNC_ENTRY, '0, tbl);
    push_beat(FUNC_ENTRY, '0, tbl);
    push_beat(FUNC_ENTRY, '0, '1);
    // large bit at the top level
    push_beat(FUNC_TRANSLATE, 48'h0000_0000_1000, '0);
    push_beat(FUNC_ENTRY, '0, '1);
    // 1 GiB page, table at address zero
    push_beat(FUNC_TRANSLATE, 48'h8000_0000_0000, '0);
    push_beat(FUNC_ENTRY, '0, 64'h1);
    push_beat(FUNC_ENTRY, '0, 64'h81);
    // 2 MiB page with all high flags
    push_beat(FUNC_TRANSLATE, 48'h0000_0000_0001, '0);
    push_beat(FUNC_ENTRY, '0, tbl);
    push_beat(FUNC_ENTRY, '0, tbl);
    push_beat(FUNC_ENTRY, '0, '1);
    // not present at the top
    push_beat(FUNC_TRANSLATE, 48'h1234_5678_9ABC, '0);
    push_beat(FUNC_ENTRY, '0, absent);
    // restart mid-walk, then not present at the last level
    push_beat(FUNC_TRANSLATE, VaW'(rand64()), '0);
    push_beat(FUNC_ENTRY, '0, tbl);
    push_beat(FUNC_TRANSLATE, VaW'(rand64()), '0);
    push_beat(FUNC_ENTRY, '0, tbl);
    push_beat(FUNC_ENTRY, '0, tbl);
    push_beat(FUNC_ENTRY, '0, 64'h1);
    push_beat(FUNC_ENTRY, '0, 64'h0);
  endtask

  initial begin
    int walk_count;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_root(52'hA_BCDE_F012_3FFF);
    directed_walks();
    for (int phase = 0; phase < 5; phase++) begin
      quiesce();
      case (phase)
        0:       write_root('1);
        1:       write_root('0);
        default: write_root(AddrW'(rand64()));
      endcase
      idle_pct  = (phase == 1) ? 58 : (phase == 3) ? 24 : 0;
      stall_pct = (phase == 2) ? 58 : (phase == 3) ? 24 : 0;
      if (phase == 0) hold_req = 1'b1;
      walk_count = 0;
      item_count = 0;
      while (item_count < PhaseItems) begin
        run_walk();
        walk_count++;
        if (phase == 1 && walk_count % 40 == 0) quiesce();
      end
    end
    quiesce();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
